@@ rtl/lz4bd_pkg.sv @@
// Shared types, constants and helpers of the LZ4 block decompressor.
`default_nettype none
package lz4bd_pkg;

  localparam int unsigned HistoryDepth = 65536;
  localparam int unsigned CapWidth     = 31;
  localparam logic [CapWidth-1:0] CapReset = 31'd65536;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_ZERO_OFF  = 3'd3,
    ST_OFF_EARLY = 3'd4
  } status_t;

  typedef enum logic {
    FN_PUSH  = 1'b0,
    FN_DRAIN = 1'b1
  } func_t;

  // One queued input beat.
  typedef struct packed {
    func_t      func;
    logic [7:0] data;
    logic       last;
  } item_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {25'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage : lz4bd_pkg
`default_nettype wire

@@ rtl/lz4bd_front.sv @@
// Front end: accepts input beats, classifies them and queues them for the back end.
`default_nettype none
module lz4bd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           in_func,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_last,
  output logic                q_valid,
  output lz4bd_pkg::item_t    q_item,
  input  wire logic           q_pop
);
  import lz4bd_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{func: (in_func ? FN_DRAIN : FN_PUSH), data: in_byte, last: in_last};
    end
  end

endmodule : lz4bd_front
`default_nettype wire

@@ rtl/lz4bd_back.sv @@
// Back end: parser state, history memory and the result register.
`default_nettype none
module lz4bd_back #(
  parameter int unsigned HISTORY_DEPTH = lz4bd_pkg::HistoryDepth
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_valid,
  input  wire lz4bd_pkg::item_t                 q_item,
  output logic                                  q_pop,
  input  wire logic [lz4bd_pkg::CapWidth-1:0]   cap,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            out_byte,
  output logic                                  out_byte_valid,
  output logic                                  out_copy_pending,
  output logic                                  out_rejected,
  output logic                                  out_block_done,
  output logic [2:0]                            out_status,
  output logic [lz4bd_pkg::CapWidth-1:0]        out_total_len
);
  import lz4bd_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LITEXT, PH_LIT, PH_OFFLO, PH_OFFHI, PH_MEXT, PH_COPY, PH_DISCARD
  } phase_t;

  phase_t      ph_r, ph_nxt;
  logic [3:0]  nib_r, nib_nxt;
  logic [31:0] lit_r, lit_nxt;
  logic [31:0] mrem_r, mrem_nxt;
  logic [15:0] off_r, off_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  status_t     err_r, err_nxt;
  logic        end_r, end_nxt;

  logic [7:0]  mem [HISTORY_DEPTH];
  logic [7:0]  rd_data_r;
  logic [AW-1:0] rd_addr;

  // result register
  logic            s2_valid_r;
  logic            s2_wr_r;
  logic [AW-1:0]   s2_addr_r;
  logic            s2_mem_r;
  logic [7:0]      s2_lit_r;
  logic            s2_bv_r, s2_pend_r, s2_rej_r, s2_done_r;
  status_t         s2_status_r;
  logic [CapWidth-1:0] s2_total_r;
  logic [7:0]      s2_byte;

  logic            bv, rej, done, use_mem, fail_req, fail_last;
  status_t         fail_code;
  logic [7:0]      ob;
  logic [32:0]     fit_sum;
  logic            adv;

  assign adv   = q_valid && (!s2_valid_r || !out_stall);
  assign q_pop = adv;
  assign rd_addr = AW'(cnt_r - {16'd0, off_r});
  assign s2_byte = s2_mem_r ? rd_data_r : s2_lit_r;

  always_comb begin
    ph_nxt = ph_r; nib_nxt = nib_r; lit_nxt = lit_r; mrem_nxt = mrem_r;
    off_nxt = off_r; cnt_nxt = cnt_r; err_nxt = err_r; end_nxt = end_r;
    ob = 8'd0; bv = 1'b0; rej = 1'b0; done = 1'b0; use_mem = 1'b0;
    fail_req = 1'b0; fail_last = 1'b0; fail_code = ST_OK;
    fit_sum = 33'd0;
    if (q_item.func == FN_DRAIN) begin
      if (ph_r != PH_COPY) begin
        rej = 1'b1;
      end else begin
        use_mem  = 1'b1;
        bv       = 1'b1;
        cnt_nxt  = cnt_r + 32'd1;
        mrem_nxt = mrem_r - 32'd1;
        if (mrem_nxt == 32'd0) begin
          if (end_r) done = 1'b1;
          else ph_nxt = PH_TOKEN;
        end
      end
    end else if (ph_r == PH_COPY) begin
      rej = 1'b1;
    end else begin
      unique case (ph_r)
        PH_TOKEN: begin
          lit_nxt = {28'd0, q_item.data[7:4]};
          nib_nxt = q_item.data[3:0];
          fit_sum = {1'b0, cnt_r} + {1'b0, lit_nxt};
          if (q_item.last) begin
            if (q_item.data[7:4] == 4'd0) done = 1'b1;
            else begin fail_req = 1'b1; fail_code = ST_TRUNCATED; fail_last = 1'b1; end
          end else if (q_item.data[7:4] == 4'hF) begin
            ph_nxt = PH_LITEXT;
          end else if (q_item.data[7:4] != 4'd0) begin
            if (fit_sum <= {2'd0, cap}) ph_nxt = PH_LIT;
            else begin fail_req = 1'b1; fail_code = ST_OVERFLOW; end
          end else begin
            ph_nxt = PH_OFFLO;
          end
        end
        PH_LITEXT: begin
          lit_nxt = sat_add(lit_r, q_item.data);
          fit_sum = {1'b0, cnt_r} + {1'b0, lit_nxt};
          if (q_item.last) begin
            fail_req = 1'b1; fail_code = ST_TRUNCATED; fail_last = 1'b1;
          end else if (q_item.data != 8'hFF) begin
            if (fit_sum <= {2'd0, cap}) ph_nxt = PH_LIT;
            else begin fail_req = 1'b1; fail_code = ST_OVERFLOW; end
          end
        end
        PH_LIT: begin
          ob = q_item.data;
          bv = 1'b1;
          cnt_nxt = cnt_r + 32'd1;
          lit_nxt = lit_r - 32'd1;
          if (lit_nxt == 32'd0) begin
            if (q_item.last) done = 1'b1;
            else ph_nxt = PH_OFFLO;
          end else if (q_item.last) begin
            fail_req = 1'b1; fail_code = ST_TRUNCATED; fail_last = 1'b1;
          end
        end
        PH_OFFLO: begin
          off_nxt = {8'd0, q_item.data};
          if (q_item.last) begin
            fail_req = 1'b1; fail_code = ST_TRUNCATED; fail_last = 1'b1;
          end else begin
            ph_nxt = PH_OFFHI;
          end
        end
        PH_OFFHI: begin
          off_nxt  = {q_item.data, off_r[7:0]};
          mrem_nxt = {28'd0, nib_r} + 32'd4;
          fit_sum  = {1'b0, cnt_r} + {1'b0, mrem_nxt};
          if (off_nxt == 16'd0) begin
            fail_req = 1'b1; fail_code = ST_ZERO_OFF; fail_last = q_item.last;
          end else if ({16'd0, off_nxt} > cnt_r) begin
            fail_req = 1'b1; fail_code = ST_OFF_EARLY; fail_last = q_item.last;
          end else if (nib_r == 4'hF && !q_item.last) begin
            ph_nxt = PH_MEXT;
          end else if (fit_sum > {2'd0, cap}) begin
            fail_req = 1'b1; fail_code = ST_OVERFLOW; fail_last = q_item.last;
          end else begin
            ph_nxt  = PH_COPY;
            end_nxt = q_item.last;
          end
        end
        PH_MEXT: begin
          mrem_nxt = sat_add(mrem_r, q_item.data);
          fit_sum  = {1'b0, cnt_r} + {1'b0, mrem_nxt};
          if (q_item.data != 8'hFF || q_item.last) begin
            if (fit_sum > {2'd0, cap}) begin
              fail_req = 1'b1; fail_code = ST_OVERFLOW; fail_last = q_item.last;
            end else begin
              ph_nxt  = PH_COPY;
              end_nxt = q_item.last;
            end
          end
        end
        PH_DISCARD: begin
          if (q_item.last) done = 1'b1;
        end
        default: begin
          rej = 1'b1;
        end
      endcase
    end
    if (fail_req) begin
      err_nxt = fail_code;
      if (fail_last) done = 1'b1;
      else ph_nxt = PH_DISCARD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_TOKEN; nib_r <= 4'd0; lit_r <= 32'd0; mrem_r <= 32'd0;
      off_r <= 16'd0; cnt_r <= 32'd0; err_r <= ST_OK; end_r <= 1'b0;
      s2_valid_r <= 1'b0; s2_wr_r <= 1'b0;
    end else begin
      if (adv) begin
        if (done) begin
          // rearm for the next block
          ph_r <= PH_TOKEN; nib_r <= 4'd0; lit_r <= 32'd0; mrem_r <= 32'd0;
          off_r <= 16'd0; cnt_r <= 32'd0; err_r <= ST_OK; end_r <= 1'b0;
        end else begin
          ph_r <= ph_nxt; nib_r <= nib_nxt; lit_r <= lit_nxt; mrem_r <= mrem_nxt;
          off_r <= off_nxt; cnt_r <= cnt_nxt; err_r <= err_nxt; end_r <= end_nxt;
        end
        s2_valid_r <= 1'b1;
        s2_wr_r    <= bv;
      end else begin
        if (s2_valid_r && !out_stall) s2_valid_r <= 1'b0;
        s2_wr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_addr_r   <= AW'(cnt_r);
      s2_mem_r    <= use_mem;
      s2_lit_r    <= ob;
      s2_bv_r     <= bv;
      s2_rej_r    <= rej;
      s2_done_r   <= done;
      s2_pend_r   <= !done && (ph_nxt == PH_COPY);
      s2_status_r <= err_nxt;
      s2_total_r  <= cnt_nxt[CapWidth-1:0];
    end
  end

  // History store: write a produced byte once, bypass it to a same-edge read.
  always_ff @(posedge clk) begin
    if (s2_wr_r) mem[s2_addr_r] <= s2_byte;
    if (adv) begin
      rd_data_r <= (s2_wr_r && s2_addr_r == rd_addr) ? s2_byte : mem[rd_addr];
    end
  end

  assign out_valid        = s2_valid_r;
  assign out_byte         = s2_bv_r ? s2_byte : 8'd0;
  assign out_byte_valid   = s2_bv_r;
  assign out_copy_pending = s2_pend_r;
  assign out_rejected     = s2_rej_r;
  assign out_block_done   = s2_done_r;
  assign out_status       = s2_status_r;
  assign out_total_len    = s2_total_r;

endmodule : lz4bd_back
`default_nettype wire

@@ rtl/lz4_block_decompressor_unit.sv @@
// Top level of the LZ4 block decompressor.
// Feed one beat per cycle: func 0 pushes a compressed byte, func 1 drains one pending match
// byte while out_copy_pending is high. Every input beat gives exactly one result beat, and the
// unit sustains one beat per clock while out_stall is low: a two-entry input queue decouples
// the front from the back end, whose parser makes one state step and one history access (one
// write port, one registered read port with write bypass) per beat. A beat passes the queue,
// then the result register. The history memory has no clearing pass; match reads only reach
// bytes of the current block. cfg_ready is always high; write dst_capacity only while idle.
`default_nettype none
module lz4_block_decompressor_unit #(
  parameter int unsigned HISTORY_DEPTH = lz4bd_pkg::HistoryDepth
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lz4bd_pkg::CapWidth-1:0] cfg_dst_capacity,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_func,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           in_last,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          out_byte,
  output logic                                out_byte_valid,
  output logic                                out_copy_pending,
  output logic                                out_rejected,
  output logic                                out_block_done,
  output logic [2:0]                          out_status,
  output logic [lz4bd_pkg::CapWidth-1:0]      out_total_len
);
  import lz4bd_pkg::*;

  logic [CapWidth-1:0] cap_r;
  logic                q_valid, q_pop;
  item_t               q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CapReset;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_dst_capacity;
    end
  end

  lz4bd_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_byte, .in_last,
    .q_valid, .q_item, .q_pop
  );

  lz4bd_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop, .cap(cap_r),
    .out_valid, .out_stall, .out_byte, .out_byte_valid, .out_copy_pending,
    .out_rejected, .out_block_done, .out_status, .out_total_len
  );

endmodule : lz4_block_decompressor_unit
`default_nettype wire

@@ rtl/lz4bd_checker.sv @@
// Port-level checker for the decompressor, bound to the top level.
`default_nettype none
module lz4bd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       out_byte_valid,
  input wire logic       out_copy_pending,
  input wire logic       out_rejected,
  input wire logic       out_block_done
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled result beat changed");

  a_done_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_done |-> !out_copy_pending && !out_rejected)
    else $error("block done with copy pending or rejected");

  a_rej_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> !out_byte_valid)
    else $error("rejected beat carries a byte");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'd0)
    else $error("byte without valid is nonzero");

endmodule : lz4bd_checker

bind lz4_block_decompressor_unit lz4bd_checker u_lz4bd_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_byte, .out_byte_valid,
  .out_copy_pending, .out_rejected, .out_block_done
);
`default_nettype wire
